@@ hw/rtl/ebec_pkg.sv @@
// Shared types and constants for the encoder and button event classifier.
package ebec_pkg;

   localparam int unsigned THRESH_W   = 20;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned EVENT_W    = 3;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned PHASE_W    = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_PRESS   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE_WAIT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BTN_ENABLE   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BTN_ACT_LOW  = 2'd3;

   localparam logic [THRESH_W-1:0] LONG_PRESS_RESET   = 20'd100000;
   localparam logic [THRESH_W-1:0] RELEASE_WAIT_RESET = 20'd60000;

   localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_W-1:0] PH_PRESSED  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_RELEASED = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LONG     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DOUBLE   = 3'd4;

   localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
   localparam logic [EVENT_W-1:0] EV_UP     = 3'd1;
   localparam logic [EVENT_W-1:0] EV_DOWN   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_SHORT  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_LONG   = 3'd4;
   localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd5;

   typedef struct packed {
      logic [THRESH_W-1:0] long_press_ticks;
      logic [THRESH_W-1:0] release_wait_ticks;
      logic                button_enabled;
      logic                level_invert;
   } cfg_type;

endpackage

@@ hw/rtl/ebec_csr.sv @@
// Configuration registers of the encoder and button event classifier.
module ebec_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ebec_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ebec_pkg::CSR_DATA_W-1:0] csr_wdata,
   output ebec_pkg::cfg_type              cfg
);
   import ebec_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_LONG_PRESS:   cfg_in.long_press_ticks   = csr_wdata[THRESH_W-1:0];
            CSR_RELEASE_WAIT: cfg_in.release_wait_ticks = csr_wdata[THRESH_W-1:0];
            CSR_BTN_ENABLE:   cfg_in.button_enabled     = csr_wdata[0];
            CSR_BTN_ACT_LOW:  cfg_in.level_invert       = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks   <= LONG_PRESS_RESET;
         cfg_ff.release_wait_ticks <= RELEASE_WAIT_RESET;
         cfg_ff.button_enabled     <= 1'b1;
         cfg_ff.level_invert       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/ebec_step.sv @@
// Per-tick rotation compare and button phase machine with its tick timer.
module ebec_step #(
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned TIMER_WIDTH = 21
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic signed [COUNT_WIDTH-1:0] position_count,
   input  logic                          button_level,
   input  ebec_pkg::cfg_type             cfg,
   output logic [ebec_pkg::EVENT_W-1:0]  event_code
);
   import ebec_pkg::*;

   localparam int unsigned CMP_W = (TIMER_WIDTH > THRESH_W) ? TIMER_WIDTH : THRESH_W;

   logic signed [COUNT_WIDTH-1:0] prev_count_ff, prev_count_in;
   logic [PHASE_W-1:0]            phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]        timer_ff, timer_in;
   logic [TIMER_WIDTH-1:0]        tick;
   logic                          pressed;
   logic                          long_hit;
   logic                          wait_hit;

   always_comb begin
      pressed  = button_level ^ cfg.level_invert;
      tick     = (timer_ff != {TIMER_WIDTH{1'b1}}) ? timer_ff + TIMER_WIDTH'(1) : timer_ff;
      long_hit = CMP_W'(tick) > CMP_W'(cfg.long_press_ticks);
      wait_hit = CMP_W'(tick) > CMP_W'(cfg.release_wait_ticks);

      prev_count_in = position_count;
      phase_in      = phase_ff;
      timer_in      = timer_ff;

      if (position_count > prev_count_ff) begin
         event_code = EV_UP;
      end else if (position_count < prev_count_ff) begin
         event_code = EV_DOWN;
      end else begin
         event_code = EV_NONE;
      end

      if (cfg.button_enabled) begin
         case (phase_ff)
            PH_PRESSED: begin
               if (!pressed) begin
                  phase_in = PH_RELEASED;
                  timer_in = '0;
               end else if (long_hit) begin
                  phase_in   = PH_LONG;
                  timer_in   = '0;
                  event_code = EV_LONG;
               end else begin
                  timer_in = tick;
               end
            end
            PH_RELEASED: begin
               if (pressed) begin
                  phase_in   = PH_DOUBLE;
                  timer_in   = '0;
                  event_code = EV_DOUBLE;
               end else if (wait_hit) begin
                  phase_in   = PH_IDLE;
                  timer_in   = '0;
                  event_code = EV_SHORT;
               end else begin
                  timer_in = tick;
               end
            end
            PH_LONG, PH_DOUBLE: begin
               if (!pressed) begin
                  phase_in = PH_IDLE;
                  timer_in = '0;
               end
            end
            default: begin
               if (pressed) begin
                  phase_in = PH_PRESSED;
                  timer_in = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         phase_ff      <= PH_IDLE;
         timer_ff      <= '0;
      end else if (fire) begin
         prev_count_ff <= prev_count_in;
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
      end
   end

endmodule

@@ hw/rtl/ebec_out_reg.sv @@
// Result register with a one-beat skid stage.
module ebec_out_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ebec_pkg::EVENT_W-1:0]  in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ebec_pkg::EVENT_W-1:0]  out_data
);
   import ebec_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [EVENT_W-1:0] out_data_ff, out_data_in;
   logic [EVENT_W-1:0] skid_data_ff, skid_data_in;
   logic               in_fire;
   logic               out_free;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;
   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_fire;
            out_data_in  = in_data;
         end
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ hw/rtl/encoder_button_event_classifier.sv @@
// Top level of the encoder and button event classifier.
// One poll tick is taken per clock while req_tready is high; its single
// event beat appears on rsp_tdata in the cycle after acceptance when the result
// register is free. A one-beat skid stage takes one more tick while
// rsp_tready is low; req_tready then drops until the skid beat has moved into
// the result register. With rsp_tready held high the rate is one tick per clock.
// Configuration registers are written through csr_we/csr_addr/csr_wdata and
// should only be changed while no beat is in flight.
module encoder_button_event_classifier #(
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned TIMER_WIDTH = 21
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [COUNT_WIDTH-1:0] position_count, [COUNT_WIDTH] button_level, rest zero
   input  logic [((COUNT_WIDTH+8)/8)*8-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] event_code, rest zero
   output logic [ebec_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [ebec_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [ebec_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ebec_pkg::*;

   cfg_type            cfg;
   logic               req_fire;
   logic [EVENT_W-1:0] step_event;
   logic [EVENT_W-1:0] rsp_event;

   assign req_fire = req_tvalid && req_tready;

   ebec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ebec_step #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .position_count (req_tdata[COUNT_WIDTH-1:0]),
      .button_level   (req_tdata[COUNT_WIDTH]),
      .cfg            (cfg),
      .event_code     (step_event)
   );

   ebec_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (step_event),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_event)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_event);

endmodule

@@ hw/rtl/ebec_checker.sv @@
// Port-level checks for the encoder and button event classifier, with bind.
module ebec_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ebec_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ebec_pkg::*;

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[EVENT_W-1:0] <= EV_DOUBLE)
                     && (rsp_tdata[RSP_DATA_W-1:EVENT_W] == '0))
      else $error("event beat carries an undefined code");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted tick produced no result beat");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with the result side empty");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

endmodule

bind encoder_button_event_classifier ebec_checker u_ebec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
